### design/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared constants and types for the integer stack machine: operation and
// status codes, the data width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] KIND_PUSH = 3'd0;
	localparam logic [2:0] KIND_PALL = 3'd1;
	localparam logic [2:0] KIND_SWAP = 3'd2;
	localparam logic [2:0] KIND_PTOP = 3'd3;
	localparam logic [2:0] KIND_POP  = 3'd4;
	localparam logic [2:0] KIND_ADD  = 3'd5;

	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_SHOWN  = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_SHORT  = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;
	localparam logic [2:0] ST_HALTED = 3'd5;

	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_SHOW = 7'b0000100,
		S_RD_A = 7'b0001000,
		S_RD_B = 7'b0010000,
		S_WR   = 7'b0100000,
		S_WR2  = 7'b1000000
	} state_t;

endpackage

### design/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ism_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/ism_alu.sv
// ----------------------------------------------------------------------------
// ism_alu
// Adder for the add operation of the stack machine; the sum wraps to the word width.
// ----------------------------------------------------------------------------
module ism_alu (
	input  ism_pkg::word_t a,
	input  ism_pkg::word_t b,
	output ism_pkg::word_t sum
);

	import ism_pkg::*;

	assign sum = word_t'(a + b);

endmodule

### design/integer_stack_machine_core.sv
// ----------------------------------------------------------------------------
// integer_stack_machine_core
// Bounded operand stack of signed integers driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: an operation is transferred at a rising edge where start is high and
// busy is low. Each result appears on shown_value, status and last for exactly
// one cycle with result_valid high; the receiver cannot hold results off.
// Push, pop, unused kinds, errors and any item while halted give their result
// in the cycle after the transfer, and busy stays low, so such items may
// follow every cycle. Print top issues a read, takes the returned data and
// shows it. Print all shows its entries one entry per cycle, top first,
// limited by the single read port of the stack RAM. Add and swap read both
// entries through the one read port; add writes the sum over the lower
// one, swap rewrites both in turn. Busy is high until the final result is
// shown. Any error halts the block; from then on each item reports halted
// until reset. Reset empties the stack and clears the halt; the stack RAM
// itself is not cleared, as entries above the count are never read.
// ----------------------------------------------------------------------------
module integer_stack_machine_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          kind,
	input  ism_pkg::word_t      push_value,
	output logic                result_valid,
	output ism_pkg::word_t      shown_value,
	output logic [2:0]          status,
	output logic                last
);

	import ism_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            halted_q;
	logic [AW-1:0]   ptr_q;
	logic [2:0]      kind_q;
	word_t           a_q;
	logic            valid_q;
	word_t           shown_q;
	logic [2:0]      status_q;
	logic            last_q;

	logic            accept;
	logic [AW-1:0]   ptr_dec;
	logic [AW-1:0]   top_addr;
	logic            show_last;
	logic            we;
	logic [AW-1:0]   waddr;
	word_t           wdata;
	logic            re;
	logic [AW-1:0]   raddr;
	word_t           rdata;
	word_t           sum;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign ptr_dec   = ptr_q - 1'b1;
	assign top_addr  = AW'(count_q - 1'b1);
	assign show_last = (kind_q == KIND_PTOP) || (ptr_q == '0);

	ism_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	ism_alu u_alu (
		.a  (a_q),
		.b  (rdata),
		.sum(sum)
	);

	// RAM port steering by sequencer state.
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata;
		re    = 1'b0;
		raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !halted_q && kind == KIND_PUSH
						&& count_q < CW'(STACK_DEPTH)) begin
					we    = 1'b1;
					waddr = AW'(count_q);
					wdata = push_value;
				end
			end
			S_RD, S_RD_A: begin
				re = 1'b1;
			end
			S_SHOW: begin
				re    = !show_last;
				raddr = ptr_dec;
			end
			S_RD_B: begin
				re    = 1'b1;
				raddr = ptr_dec;
			end
			S_WR: begin
				we = 1'b1;
				if (kind_q == KIND_ADD) begin
					waddr = ptr_dec;
					wdata = sum;
				end
			end
			S_WR2: begin
				we    = 1'b1;
				waddr = ptr_dec;
				wdata = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			halted_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						ptr_q  <= top_addr;
						if (halted_q) begin
							valid_q  <= 1'b1;
							status_q <= ST_HALTED;
						end else begin
							case (kind)
								KIND_PUSH: begin
									valid_q <= 1'b1;
									if (count_q >= CW'(STACK_DEPTH)) begin
										status_q <= ST_FULL;
										halted_q <= 1'b1;
									end else begin
										status_q <= ST_DONE;
										count_q  <= count_q + 1'b1;
									end
								end
								KIND_PALL, KIND_PTOP: begin
									if (count_q == '0) begin
										valid_q  <= 1'b1;
										status_q <= ST_EMPTY;
										halted_q <= 1'b1;
									end else begin
										state_q <= S_RD;
									end
								end
								KIND_SWAP, KIND_ADD: begin
									if (count_q == '0 && kind == KIND_SWAP) begin
										valid_q  <= 1'b1;
										status_q <= ST_EMPTY;
										halted_q <= 1'b1;
									end else if (count_q < CW'(2)) begin
										valid_q  <= 1'b1;
										status_q <= ST_SHORT;
										halted_q <= 1'b1;
									end else begin
										state_q <= S_RD_A;
									end
								end
								KIND_POP: begin
									valid_q <= 1'b1;
									if (count_q == '0) begin
										status_q <= ST_EMPTY;
										halted_q <= 1'b1;
									end else begin
										status_q <= ST_DONE;
										count_q  <= count_q - 1'b1;
									end
								end
								default: begin
									valid_q  <= 1'b1;
									status_q <= ST_DONE;
								end
							endcase
						end
						shown_q <= '0;
						last_q  <= 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					// The next entry down is already being read while this one is shown.
					valid_q  <= 1'b1;
					status_q <= ST_SHOWN;
					shown_q  <= rdata;
					last_q   <= show_last;
					if (show_last) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_dec;
					end
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					a_q     <= rdata;
					state_q <= S_WR;
				end
				S_WR: begin
					if (kind_q == KIND_ADD) begin
						valid_q  <= 1'b1;
						status_q <= ST_DONE;
						shown_q  <= '0;
						last_q   <= 1'b1;
						count_q  <= count_q - 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WR2;
					end
				end
				S_WR2: begin
					valid_q  <= 1'b1;
					status_q <= ST_DONE;
					shown_q  <= '0;
					last_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = valid_q;
	assign shown_value  = shown_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer stack machine. A stack tracker class
// predicts the results of every transferred operation and matches them, in
// order, against the result strobes. Stimulus is a short directed sequence,
// then well-formed random operation streams that swing the stack between
// empty and full, and finally one deliberate error followed by items sent
// while the block is halted.
// ----------------------------------------------------------------------------

module testbench;
	import ism_pkg::*;

	localparam int         STACK_DEPTH    = 32;
	localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

	class stack_tracker;
		typedef struct {
			ism_pkg::word_t shown;
			logic [2:0]     status;
			logic           last;
		} outcome_t;

		ism_pkg::word_t entries [STACK_DEPTH];
		int unsigned    used;
		bit             halted;
		outcome_t       pending [$];
		int unsigned    fault_count;

		function void queue_outcome(ism_pkg::word_t shown, logic [2:0] stat, logic fin);
			outcome_t item;
			item.shown  = shown;
			item.status = stat;
			item.last   = fin;
			pending.push_back(item);
		endfunction

		function void halt_with(logic [2:0] stat);
			halted = 1'b1;
			queue_outcome('0, stat, 1'b1);
		endfunction

		function void note_fault(string msg);
			fault_count++;
			if (fault_count <= 10) begin
				$display("ERROR at %0t ns: %s", $time, msg);
			end
		endfunction

		// Works out every result that one transferred operation causes.
		function void apply_operation(logic [2:0] op, ism_pkg::word_t value);
			int unsigned    i;
			ism_pkg::word_t held;
			if (halted) begin
				queue_outcome('0, ism_pkg::ST_HALTED, 1'b1);
				return;
			end
			case (op)
				ism_pkg::KIND_PUSH: begin
					if (used >= STACK_DEPTH) begin
						halt_with(ism_pkg::ST_FULL);
						return;
					end
					entries[used] = value;
					used++;
				end
				ism_pkg::KIND_PALL: begin
					if (used == 0) begin
						halt_with(ism_pkg::ST_EMPTY);
						return;
					end
					for (i = used; i > 0; i--) begin
						queue_outcome(entries[i-1], ism_pkg::ST_SHOWN, i == 1);
					end
					return;
				end
				ism_pkg::KIND_SWAP: begin
					if (used == 0) begin
						halt_with(ism_pkg::ST_EMPTY);
						return;
					end
					if (used < 2) begin
						halt_with(ism_pkg::ST_SHORT);
						return;
					end
					held            = entries[used-1];
					entries[used-1] = entries[used-2];
					entries[used-2] = held;
				end
				ism_pkg::KIND_PTOP: begin
					if (used == 0) begin
						halt_with(ism_pkg::ST_EMPTY);
						return;
					end
					queue_outcome(entries[used-1], ism_pkg::ST_SHOWN, 1'b1);
					return;
				end
				ism_pkg::KIND_POP: begin
					if (used == 0) begin
						halt_with(ism_pkg::ST_EMPTY);
						return;
					end
					used--;
				end
				ism_pkg::KIND_ADD: begin
					if (used < 2) begin
						halt_with(ism_pkg::ST_SHORT);
						return;
					end
					entries[used-2] = entries[used-2] + entries[used-1];
					used--;
				end
				default: ;
			endcase
			queue_outcome('0, ism_pkg::ST_DONE, 1'b1);
		endfunction

		function void compare_result(ism_pkg::word_t shown, logic [2:0] stat, logic fin);
			outcome_t want;
			if (pending.size() == 0) begin
				note_fault($sformatf("unexpected result: shown %h status %0d last %b",
					shown, stat, fin));
				return;
			end
			want = pending.pop_front();
			if (shown !== want.shown || stat !== want.status || fin !== want.last) begin
				note_fault($sformatf(
					"result mismatch: expected shown %h status %0d last %b, got %h %0d %b",
					want.shown, want.status, want.last, shown, stat, fin));
			end
		endfunction
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [2:0] kind       = KIND_PUSH;
	word_t      push_value = '0;
	logic       busy;
	logic       result_valid;
	word_t      shown_value;
	logic [2:0] status;
	logic       last;

	int burst_left = 0;

	stack_tracker tracker = new();

	integer_stack_machine_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.push_value  (push_value),
		.result_valid(result_valid),
		.shown_value (shown_value),
		.status      (status),
		.last        (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Extremes turn up often so that add wraps and sign bits are exercised.
	function automatic word_t pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Holds one operation on the inputs until its transfer, then either leaves
	// start high for the next one or opens an idle gap between bursts.
	task automatic drive_item(input logic [2:0] op, input word_t value);
		int gap;
		start      <= 1'b1;
		kind       <= op;
		push_value <= value;
		do @(posedge clk); while (busy);
		tracker.apply_operation(op, value);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = $urandom_range(1, 6);
			start      <= 1'b0;
			kind       <= 3'($urandom);
			push_value <= $urandom;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end
	endtask

	always @(posedge clk) begin
		if (result_valid === 1'b1) begin
			tracker.compare_result(shown_value, status, last);
		end
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned target;
		int unsigned r;
		int unsigned fault_depth;
		logic [2:0]  op;
		logic [2:0]  fault_op;
		bit          show_full;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused kinds, sign extremes, wrapping adds, single-entry
		// print all and popping the only entry.
		drive_item(KIND_UNUSED_LO, 32'hFFFF_FFFF);
		drive_item(KIND_UNUSED_HI, 32'h0000_0000);
		drive_item(KIND_PUSH, 32'h7FFF_FFFF);
		drive_item(KIND_PUSH, 32'h8000_0000);
		drive_item(KIND_PTOP, 32'h0000_0000);
		drive_item(KIND_SWAP, 32'h0000_0000);
		drive_item(KIND_PALL, 32'h0000_0000);
		drive_item(KIND_ADD, 32'h0000_0000);
		drive_item(KIND_PTOP, 32'h0000_0000);
		drive_item(KIND_PUSH, 32'h0000_0001);
		drive_item(KIND_ADD, 32'h0000_0000);
		drive_item(KIND_PUSH, 32'h7FFF_FFFF);
		drive_item(KIND_PUSH, 32'h0000_0001);
		drive_item(KIND_ADD, 32'h0000_0000);
		drive_item(KIND_PALL, 32'h0000_0000);
		drive_item(KIND_POP, 32'h0000_0000);
		drive_item(KIND_POP, 32'h0000_0000);
		drive_item(KIND_PUSH, 32'h0000_0000);
		drive_item(KIND_PALL, 32'hFFFF_FFFF);
		drive_item(KIND_POP, 32'h0000_0000);
		drive_item(KIND_PUSH, 32'hFFFF_FFFF);
		drive_item(KIND_PTOP, 32'h0000_0000);
		drive_item(KIND_POP, 32'h0000_0000);

		// Random part: the stack depth drifts towards a target that is
		// re-drawn whenever it is reached, empty and full among the choices.
		counted = 0;
		target  = 4;
		while (counted < 250) begin
			show_full = 1'b0;
			if (tracker.used == target) begin
				show_full = (target == STACK_DEPTH);
				case ($urandom_range(3))
					0: target = 0;
					1: target = STACK_DEPTH;
					default: target = $urandom_range(1, 8);
				endcase
			end
			r = $urandom_range(99);
			if (show_full) op = KIND_PALL;
			else if (r < 6) op = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
			else if (r < 60) op = (tracker.used < target) ? KIND_PUSH
				: ((r % 2) ? KIND_ADD : KIND_POP);
			else if (r < 70) op = KIND_PTOP;
			else if (r < 80) op = KIND_SWAP;
			else if (r < 88) op = KIND_ADD;
			else if (r < 93) op = KIND_PALL;
			else op = KIND_PUSH;

			// Keep the stream well formed, since any error halts until reset.
			if (op == KIND_PUSH && tracker.used >= STACK_DEPTH) begin
				op = KIND_POP;
			end else if ((op == KIND_SWAP || op == KIND_ADD) && tracker.used < 2) begin
				op = KIND_PUSH;
			end else if ((op == KIND_PTOP || op == KIND_PALL || op == KIND_POP)
				&& tracker.used == 0) begin
				op = KIND_PUSH;
			end
			if (op < KIND_UNUSED_LO) counted++;
			drive_item(op, pick_value());
		end

		// Only one error can be provoked per run, so the seed picks which.
		case ($urandom_range(7))
			0: begin fault_depth = STACK_DEPTH; fault_op = KIND_PUSH; end
			1: begin fault_depth = 0; fault_op = KIND_PALL; end
			2: begin fault_depth = 0; fault_op = KIND_SWAP; end
			3: begin fault_depth = 0; fault_op = KIND_PTOP; end
			4: begin fault_depth = 0; fault_op = KIND_POP; end
			5: begin fault_depth = 1; fault_op = KIND_SWAP; end
			6: begin fault_depth = 1; fault_op = KIND_ADD; end
			default: begin fault_depth = 0; fault_op = KIND_ADD; end
		endcase
		while (tracker.used < fault_depth) drive_item(KIND_PUSH, pick_value());
		while (tracker.used > fault_depth) drive_item(KIND_POP, pick_value());
		drive_item(fault_op, pick_value());
		repeat (10) drive_item(3'($urandom_range(KIND_UNUSED_HI)), pick_value());

		start <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
